FILE: hdl/hkqm_pkg.sv
package hkqm_pkg;

   localparam int COORD_BITS = 12;
   localparam int CNT_W      = 12;
   localparam int FRAC_W     = 4;
   localparam int VERT_W     = COORD_BITS + FRAC_W;
   localparam int SLOT_W     = 16;
   localparam int PNT_W      = CNT_W + FRAC_W;
   localparam int DIFF_W     = PNT_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int HUE_W      = 10;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int NUM_VERT   = 4;

   typedef logic [2:0] reg_idx_type;

   localparam reg_idx_type REG_HUE_MIN     = 3'd0;
   localparam reg_idx_type REG_HUE_MAX     = 3'd1;
   localparam reg_idx_type REG_SAT_MIN     = 3'd2;
   localparam reg_idx_type REG_VAL_MIN     = 3'd3;
   localparam reg_idx_type REG_FRAME_WIDTH = 3'd4;
   localparam reg_idx_type REG_WARPED_MODE = 3'd5;
   localparam reg_idx_type REG_QUAD_FIRST  = 3'd6;
   localparam reg_idx_type REG_QUAD_SECOND = 3'd7;

   localparam logic [HUE_W-1:0] HUE_MIN_RESET     = 10'd0;
   localparam logic [HUE_W-1:0] HUE_MAX_RESET     = 10'd255;
   localparam logic [CNT_W-1:0] FRAME_WIDTH_RESET = 12'd320;

   typedef struct packed {
      logic [7:0] hue;
      logic [7:0] sat;
      logic [7:0] val;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic             pixel_on;
      logic [CNT_W-1:0] column;
      logic [CNT_W-1:0] row;
   } rsp_type;

   typedef struct packed {
      logic [PNT_W-1:0] x;
      logic [PNT_W-1:0] y;
   } point_type;

   function automatic logic [PNT_W-1:0] vertex_coord(logic [SLOT_W-1:0] slot);
      return PNT_W'(slot[VERT_W-1:0]);
   endfunction

   function automatic logic hue_in_window(logic signed [HUE_W:0] h,
                                          logic [HUE_W-1:0] lo,
                                          logic [HUE_W-1:0] hi);
      return (h >= $signed(lo)) && (h <= $signed(hi));
   endfunction

endpackage

FILE: hdl/hkqm_edge.sv
module hkqm_edge (
   input  logic                clock,
   input  logic                load,
   input  hkqm_pkg::point_type pnt,
   input  hkqm_pkg::point_type va,
   input  hkqm_pkg::point_type vb,
   output logic                crossing
);
   import hkqm_pkg::*;

   logic signed [DIFF_W-1:0] dy;
   logic signed [DIFF_W-1:0] dx_pnt;
   logic signed [DIFF_W-1:0] dx_edge;
   logic signed [DIFF_W-1:0] dy_pnt;
   logic signed [PROD_W-1:0] lhs_in, lhs_ff;
   logic signed [PROD_W-1:0] rhs_in, rhs_ff;
   logic                     spans_in, spans_ff;
   logic                     dypos_in, dypos_ff;

   assign dy      = $signed({1'b0, vb.y})  - $signed({1'b0, va.y});
   assign dx_pnt  = $signed({1'b0, pnt.x}) - $signed({1'b0, va.x});
   assign dx_edge = $signed({1'b0, vb.x})  - $signed({1'b0, va.x});
   assign dy_pnt  = $signed({1'b0, pnt.y}) - $signed({1'b0, va.y});

   assign lhs_in   = dx_pnt * dy;
   assign rhs_in   = dx_edge * dy_pnt;
   assign spans_in = ((va.y <= pnt.y) && (pnt.y < vb.y)) ||
                     ((vb.y <= pnt.y) && (pnt.y < va.y));
   assign dypos_in = vb.y > va.y;

   always_ff @(posedge clock) begin
      if (load) begin
         lhs_ff   <= lhs_in;
         rhs_ff   <= rhs_in;
         spans_ff <= spans_in;
         dypos_ff <= dypos_in;
      end
   end

   assign crossing = spans_ff && (dypos_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff));

endmodule

FILE: hdl/hsv_key_quad_mask.sv
// hsv color key with a four-vertex quad mask
//
// req channel: one hsv pixel per transfer in raster order; frame_start
// clears column and row before that pixel. rsp channel: one transfer per
// pixel with the mask bit and the column and row used for it.
// csr port: apb-style, 64-bit data, register i at byte address 8*i; pready
// is always high and writes land at the access cycle. the user must write
// registers only while the pipeline is empty; the block does not enforce it.
//
// rsp valid comes from the third stage register. throughput: one pixel
// per cycle; a new pixel is taken every cycle while rsp is not stalled.
// the pipeline is three registered stages: counters and color key, the
// cross products of every quad edge, then the even-odd crossing vote.
// rsp_stall holds the result register; empty stages still fill, so req_stall
// rises only when all three stages hold a pixel.
// reset empties the pipeline, clears column and row and loads the register
// reset values (full hue window, width 320, zero quad).
module hsv_key_quad_mask (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  hkqm_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output hkqm_pkg::rsp_type                   rsp_data,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [hkqm_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [hkqm_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [hkqm_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import hkqm_pkg::*;

   // configuration registers
   logic [HUE_W-1:0]      hue_min_ff;
   logic [HUE_W-1:0]      hue_max_ff;
   logic [7:0]            sat_min_ff;
   logic [7:0]            val_min_ff;
   logic [CNT_W-1:0]      frame_width_ff;
   logic                  warped_ff;
   logic [CSR_DATA_W-1:0] quad_first_ff;
   logic [CSR_DATA_W-1:0] quad_second_ff;
   logic                  csr_write;
   reg_idx_type           csr_idx;

   // pipeline control
   logic a_valid_ff, b_valid_ff, o_valid_ff;
   logic ready_a, ready_b, ready_o;
   logic accept, load_b, load_o;

   // counters
   logic [CNT_W-1:0] col_ff, col_in;
   logic [CNT_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] cur_col, cur_row;

   // stage payloads
   logic                  color_ok;
   logic                  a_color_ff;
   logic [CNT_W-1:0]      a_col_ff, a_row_ff;
   logic                  b_color_ff;
   logic [CNT_W-1:0]      b_col_ff, b_row_ff;
   rsp_type               rsp_ff;
   logic signed [HUE_W:0] h_base;

   point_type               pnt;
   point_type [NUM_VERT-1:0] vert;
   logic [NUM_VERT-1:0]      crossing;
   logic                     quad_hit;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_min_ff     <= HUE_MIN_RESET;
         hue_max_ff     <= HUE_MAX_RESET;
         sat_min_ff     <= '0;
         val_min_ff     <= '0;
         frame_width_ff <= FRAME_WIDTH_RESET;
         warped_ff      <= 1'b0;
         quad_first_ff  <= '0;
         quad_second_ff <= '0;
      end else if (csr_write) begin
         case (csr_idx)
            REG_HUE_MIN:     hue_min_ff     <= csr_pwdata[HUE_W-1:0];
            REG_HUE_MAX:     hue_max_ff     <= csr_pwdata[HUE_W-1:0];
            REG_SAT_MIN:     sat_min_ff     <= csr_pwdata[7:0];
            REG_VAL_MIN:     val_min_ff     <= csr_pwdata[7:0];
            REG_FRAME_WIDTH: frame_width_ff <= csr_pwdata[CNT_W-1:0];
            REG_WARPED_MODE: warped_ff      <= csr_pwdata[0];
            REG_QUAD_FIRST:  quad_first_ff  <= csr_pwdata;
            REG_QUAD_SECOND: quad_second_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HUE_MIN:     csr_prdata = CSR_DATA_W'(hue_min_ff);
         REG_HUE_MAX:     csr_prdata = CSR_DATA_W'(hue_max_ff);
         REG_SAT_MIN:     csr_prdata = CSR_DATA_W'(sat_min_ff);
         REG_VAL_MIN:     csr_prdata = CSR_DATA_W'(val_min_ff);
         REG_FRAME_WIDTH: csr_prdata = CSR_DATA_W'(frame_width_ff);
         REG_WARPED_MODE: csr_prdata = CSR_DATA_W'(warped_ff);
         REG_QUAD_FIRST:  csr_prdata = quad_first_ff;
         REG_QUAD_SECOND: csr_prdata = quad_second_ff;
         default:         csr_prdata = '0;
      endcase
   end

   assign ready_o   = !o_valid_ff || !rsp_stall;
   assign ready_b   = !b_valid_ff || ready_o;
   assign ready_a   = !a_valid_ff || ready_b;
   assign req_stall = !ready_a;
   assign accept    = req_valid && ready_a;
   assign load_b    = a_valid_ff && ready_b;
   assign load_o    = b_valid_ff && ready_o;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         col_ff     <= '0;
         row_ff     <= '0;
      end else begin
         if (ready_a) a_valid_ff <= req_valid;
         if (ready_b) b_valid_ff <= a_valid_ff;
         if (ready_o) o_valid_ff <= b_valid_ff;
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // row wrap happens before the pixel is used
   always_comb begin
      if (req_data.frame_start) begin
         cur_col = '0;
         cur_row = '0;
      end else if (col_ff >= frame_width_ff) begin
         cur_col = '0;
         cur_row = row_ff + 1'b1;
      end else begin
         cur_col = col_ff;
         cur_row = row_ff;
      end
      col_in = accept ? cur_col + 1'b1 : col_ff;
      row_in = accept ? cur_row : row_ff;
   end

   assign h_base   = $signed({3'b000, req_data.hue});
   assign color_ok = (req_data.sat >= sat_min_ff) && (req_data.val >= val_min_ff) &&
                     ((sat_min_ff == '0) ||
                      hue_in_window(h_base, hue_min_ff, hue_max_ff) ||
                      hue_in_window(h_base - 11'sd255, hue_min_ff, hue_max_ff) ||
                      hue_in_window(h_base + 11'sd255, hue_min_ff, hue_max_ff));

   always_ff @(posedge clock) begin
      if (accept) begin
         a_color_ff <= color_ok;
         a_col_ff   <= cur_col;
         a_row_ff   <= cur_row;
      end
      if (load_b) begin
         b_color_ff <= a_color_ff;
         b_col_ff   <= a_col_ff;
         b_row_ff   <= a_row_ff;
      end
      if (load_o) begin
         rsp_ff.pixel_on <= b_color_ff && (warped_ff || quad_hit);
         rsp_ff.column   <= b_col_ff;
         rsp_ff.row      <= b_row_ff;
      end
   end

   assign pnt.x = {a_col_ff, {FRAC_W{1'b0}}};
   assign pnt.y = {a_row_ff, {FRAC_W{1'b0}}};

   assign vert[0].x = vertex_coord(quad_first_ff[15:0]);
   assign vert[0].y = vertex_coord(quad_first_ff[31:16]);
   assign vert[1].x = vertex_coord(quad_first_ff[47:32]);
   assign vert[1].y = vertex_coord(quad_first_ff[63:48]);
   assign vert[2].x = vertex_coord(quad_second_ff[15:0]);
   assign vert[2].y = vertex_coord(quad_second_ff[31:16]);
   assign vert[3].x = vertex_coord(quad_second_ff[47:32]);
   assign vert[3].y = vertex_coord(quad_second_ff[63:48]);

   for (genvar e = 0; e < NUM_VERT; e++) begin : g_edge
      hkqm_edge u_edge (
         .clock    (clock),
         .load     (load_b),
         .pnt      (pnt),
         .va       (vert[e]),
         .vb       (vert[(e + NUM_VERT - 1) % NUM_VERT]),
         .crossing (crossing[e])
      );
   end

   assign quad_hit  = ^crossing;
   assign rsp_valid = o_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: hdl/hkqm_checker.sv
module hkqm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input hkqm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input hkqm_pkg::rsp_type rsp_data
);
   import hkqm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && !rsp_stall) ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("pixel did not reach rsp in three cycles");

   a_frame_origin: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.frame_start && !rsp_stall)
      ##1 !rsp_stall ##1 !rsp_stall
      |=> (rsp_data.column == '0) && (rsp_data.row == '0))
      else $error("frame start pixel not at origin");

endmodule

bind hsv_key_quad_mask hkqm_checker u_hkqm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

FILE: bench/mask_check_pkg.sv
`timescale 1ns / 100ps
package mask_check_pkg;
   import hkqm_pkg::*;

   class mask_scoreboard;
      logic [HUE_W-1:0] hue_lo;
      logic [HUE_W-1:0] hue_hi;
      logic [7:0]       sat_floor;
      logic [7:0]       val_floor;
      logic [CNT_W-1:0] width;
      logic             warped;
      logic [63:0]      quad_a;
      logic [63:0]      quad_b;
      logic [CNT_W-1:0] col;
      logic [CNT_W-1:0] row;
      rsp_type          expected_masks[$];
      int               errors;

      function new();
         hue_lo    = HUE_MIN_RESET;
         hue_hi    = HUE_MAX_RESET;
         sat_floor = '0;
         val_floor = '0;
         width     = FRAME_WIDTH_RESET;
         warped    = 1'b0;
         quad_a    = '0;
         quad_b    = '0;
         col       = '0;
         row       = '0;
         errors    = 0;
      endfunction

      function void write_reg(reg_idx_type idx, logic [63:0] value);
         case (idx)
            REG_HUE_MIN:     hue_lo = value[HUE_W-1:0];
            REG_HUE_MAX:     hue_hi = value[HUE_W-1:0];
            REG_SAT_MIN:     sat_floor = value[7:0];
            REG_VAL_MIN:     val_floor = value[7:0];
            REG_FRAME_WIDTH: width = value[CNT_W-1:0];
            REG_WARPED_MODE: warped = value[0];
            REG_QUAD_FIRST:  quad_a = value;
            REG_QUAD_SECOND: quad_b = value;
            default: ;
         endcase
      endfunction

      function bit hue_hit(int h);
         return h >= int'($signed(hue_lo)) && h <= int'($signed(hue_hi));
      endfunction

      // even-odd crossing count, divisions replaced by cross products
      function bit in_quad(longint px, longint py);
         longint vx[NUM_VERT];
         longint vy[NUM_VERT];
         longint dy;
         longint lhs;
         longint rhs;
         bit     odd;
         int     b;
         vx[0] = longint'(quad_a[15:0]);
         vy[0] = longint'(quad_a[31:16]);
         vx[1] = longint'(quad_a[47:32]);
         vy[1] = longint'(quad_a[63:48]);
         vx[2] = longint'(quad_b[15:0]);
         vy[2] = longint'(quad_b[31:16]);
         vx[3] = longint'(quad_b[47:32]);
         vy[3] = longint'(quad_b[63:48]);
         odd = 1'b0;
         for (int a = 0; a < NUM_VERT; a++) begin
            b = (a == 0) ? NUM_VERT - 1 : a - 1;
            if ((vy[a] <= py && py < vy[b]) || (vy[b] <= py && py < vy[a])) begin
               dy  = vy[b] - vy[a];
               lhs = (px - vx[a]) * dy;
               rhs = (vx[b] - vx[a]) * (py - vy[a]);
               if ((dy > 0) ? (lhs < rhs) : (lhs > rhs))
                  odd = !odd;
            end
         end
         return odd;
      endfunction

      function void note_pixel(req_type p);
         rsp_type want;
         int      h;
         if (p.frame_start) begin
            col = '0;
            row = '0;
         end else if (col >= width) begin
            col = '0;
            row = row + 1'b1;
         end
         want.pixel_on = 1'b0;
         want.column   = col;
         want.row      = row;
         h = int'(p.hue);
         if (p.sat >= sat_floor && p.val >= val_floor &&
             (sat_floor == 0 || hue_hit(h) || hue_hit(h - 255) || hue_hit(h + 255)))
            want.pixel_on = warped ? 1'b1 :
                            in_quad(longint'(col) * 16, longint'(row) * 16);
         expected_masks.push_back(want);
         col = col + 1'b1;
      endfunction

      task flag(string what);
         if (errors < 20)
            $display("mismatch: %s", what);
         errors++;
      endtask

      task check_result(rsp_type got);
         rsp_type want;
         if (expected_masks.size() == 0) begin
            flag($sformatf("unexpected transfer on=%0b col=%0d row=%0d",
                           got.pixel_on, got.column, got.row));
            return;
         end
         want = expected_masks.pop_front();
         if (got.pixel_on !== want.pixel_on)
            flag($sformatf("pixel_on %0b, expected %0b at col=%0d row=%0d",
                           got.pixel_on, want.pixel_on, want.column, want.row));
         if (got.column !== want.column)
            flag($sformatf("column %0d, expected %0d", got.column, want.column));
         if (got.row !== want.row)
            flag($sformatf("row %0d, expected %0d", got.row, want.row));
      endtask
   endclass

endpackage

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import hkqm_pkg::*;
   import mask_check_pkg::*;

   typedef enum int {
      FLOW_FREE,
      FLOW_SENDER_GAPS,
      FLOW_RECEIVER_STALLS,
      FLOW_BOTH
   } flow_mode_type;

   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 6;
   localparam int HOLD_CYCLES   = 48;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_PIXELS  = 146;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int gap_pct      = 0;
   int stall_pct    = 0;
   int hold_request = 0;
   int hold_left    = 0;
   int cycle_count  = 0;
   int cur_sat_min  = 0;
   int cur_val_min  = 0;

   mask_scoreboard mask_book;
   req_type        script[$];

   hsv_key_quad_mask u_top (.*);

   initial forever #2 clock = ~clock;

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            mask_book.note_pixel(req_data);
         if (rsp_valid && !rsp_stall)
            mask_book.check_result(rsp_data);
      end
   end

   // receiver side, with an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic csr_write(input reg_idx_type idx, input logic [63:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mask_book.write_reg(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_regs(input int hue_lo, input int hue_hi, input int sat_lo,
                               input int val_lo, input int width, input int warp,
                               input logic [63:0] quad_a, input logic [63:0] quad_b);
      csr_write(REG_HUE_MIN, 64'(hue_lo[HUE_W-1:0]));
      csr_write(REG_HUE_MAX, 64'(hue_hi[HUE_W-1:0]));
      csr_write(REG_SAT_MIN, 64'(sat_lo[7:0]));
      csr_write(REG_VAL_MIN, 64'(val_lo[7:0]));
      csr_write(REG_FRAME_WIDTH, 64'(width[CNT_W-1:0]));
      csr_write(REG_WARPED_MODE, 64'(warp[0]));
      csr_write(REG_QUAD_FIRST, quad_a);
      csr_write(REG_QUAD_SECOND, quad_b);
      cur_sat_min = sat_lo;
      cur_val_min = val_lo;
   endtask

   task automatic send_pixel(input req_type p);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic release_req;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic wait_empty;
      while (mask_book.expected_masks.size() != 0) @(posedge clock);
   endtask

   task automatic settle;
      wait_empty();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type make_pixel(input int hue, input int sat, input int val,
                                          input bit start);
      req_type p;
      p.hue         = hue[7:0];
      p.sat         = sat[7:0];
      p.val         = val[7:0];
      p.frame_start = start;
      return p;
   endfunction

   function automatic req_type random_pixel(input bit allow_start);
      req_type p;
      p.hue = 8'($urandom_range(255));
      p.sat = ($urandom_range(9) < 7) ? 8'($urandom_range(255, cur_sat_min)) :
                                        8'($urandom_range(255));
      p.val = ($urandom_range(9) < 7) ? 8'($urandom_range(255, cur_val_min)) :
                                        8'($urandom_range(255));
      p.frame_start = allow_start && ($urandom_range(199) == 0);
      return p;
   endfunction

   function automatic logic [31:0] random_vertex(input int xspan, input int yspan);
      logic [15:0] x;
      logic [15:0] y;
      if ($urandom_range(6) == 0)
         return $urandom();
      x = 16'($urandom_range(xspan));
      y = 16'($urandom_range(yspan));
      return {y, x};
   endfunction

   task automatic run_script;
      gap_pct   = 0;
      stall_pct = 0;
      foreach (script[i])
         send_pixel(script[i]);
      script.delete();
      release_req();
      settle();
   endtask

   task automatic run_random(input int count, input flow_mode_type mode,
                             input bit allow_start);
      req_type p;
      case (mode)
         FLOW_FREE:            begin gap_pct = 0;  stall_pct = 0;  end
         FLOW_SENDER_GAPS:     begin gap_pct = 68; stall_pct = 0;  end
         FLOW_RECEIVER_STALLS: begin gap_pct = 0;  stall_pct = 68; end
         default:              begin gap_pct = 9;  stall_pct = 9;  end
      endcase
      for (int i = 0; i < count; i++) begin
         p = random_pixel(allow_start);
         if (i == 0)
            p.frame_start = 1'b1;
         if (mode == FLOW_FREE && i == count / 3)
            hold_request = HOLD_CYCLES;
         if (mode == FLOW_SENDER_GAPS && i == count / 2) begin
            release_req();
            wait_empty();
         end
         send_pixel(p);
      end
      release_req();
      settle();
   endtask

   initial begin
      int            hlo;
      int            hhi;
      int            width;
      int            rows;
      int            xspan;
      int            yspan;
      int            sat_lo;
      int            val_lo;
      logic [63:0]   qa;
      logic [63:0]   qb;
      flow_mode_type mode;

      mask_book = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset values: zero quad keeps every pixel off
      script.push_back(make_pixel(0, 0, 0, 1'b1));
      script.push_back(make_pixel(255, 255, 255, 1'b0));
      script.push_back(make_pixel(128, 1, 1, 1'b0));
      run_script();

      // widest hue window, strict value floor, zero width, warped
      program_regs(-255, 510, 1, 255, 0, 1, '0, '0);
      script.push_back(make_pixel(0, 255, 255, 1'b0));
      script.push_back(make_pixel(255, 1, 255, 1'b0));
      script.push_back(make_pixel(40, 0, 255, 1'b0));
      script.push_back(make_pixel(40, 200, 254, 1'b0));
      script.push_back(make_pixel(90, 255, 255, 1'b1));
      run_script();

      // empty hue window
      program_regs(10, 5, 255, 0, 4095, 1, '0, '0);
      script.push_back(make_pixel(7, 255, 0, 1'b0));
      script.push_back(make_pixel(10, 255, 9, 1'b0));
      run_script();

      // window above 255 reached through h+255
      program_regs(250, 260, 1, 0, 4095, 1, '0, '0);
      script.push_back(make_pixel(3, 9, 9, 1'b0));
      script.push_back(make_pixel(251, 9, 9, 1'b0));
      script.push_back(make_pixel(5, 9, 9, 1'b0));
      script.push_back(make_pixel(6, 9, 9, 1'b0));
      run_script();

      // negative window reached through h-255
      program_regs(-10, 5, 1, 0, 4095, 1, '0, '0);
      script.push_back(make_pixel(250, 9, 9, 1'b0));
      run_script();

      // small rectangular quad on a five pixel wide frame
      program_regs(0, 255, 0, 0, 5, 0, {16'd16, 16'd64, 16'd16, 16'd16},
                   {16'd48, 16'd16, 16'd48, 16'd64});
      for (int i = 0; i < 12; i++)
         script.push_back(make_pixel(100, 100, 100, i == 0));
      run_script();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         mode  = flow_mode_type'(ph % 4);
         width = (ph == 5) ? 4095 : (ph == 9) ? 1 : $urandom_range(40, 4);
         rows  = PHASE_PIXELS / width + 2;
         xspan = ((width + 1) * 16 > 65535) ? 65535 : (width + 1) * 16;
         yspan = (rows * 16 > 65535) ? 65535 : rows * 16;
         hlo   = int'($urandom_range(765)) - 255;
         if ($urandom_range(7) == 0)
            hhi = hlo - 1 - int'($urandom_range(30));
         else
            hhi = hlo + int'($urandom_range(150));
         if (hhi > 510)
            hhi = 510;
         if (hhi < -255)
            hhi = -255;
         if (ph == 2) begin
            hlo = -255;
            hhi = 510;
         end
         sat_lo = ($urandom_range(3) == 0) ? 0 : $urandom_range(255);
         val_lo = $urandom_range(128);
         if (ph == 3)
            sat_lo = 255;
         if (ph == 7)
            val_lo = 255;
         qa = {random_vertex(xspan, yspan), random_vertex(xspan, yspan)};
         qb = {random_vertex(xspan, yspan), random_vertex(xspan, yspan)};
         // horizontal edge
         if ($urandom_range(5) == 0)
            qa[63:48] = qa[31:16];
         program_regs(hlo, hhi, sat_lo, val_lo, width, int'($urandom_range(3) == 0),
                      qa, qb);
         run_random(PHASE_PIXELS, mode, 1'b1);
      end

      if (mask_book.errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/hkqm_pkg.sv
hdl/hkqm_edge.sv
hdl/hsv_key_quad_mask.sv
hdl/hkqm_checker.sv
bench/mask_check_pkg.sv
bench/tb_top.sv
